### rtl/psdc_pkg.sv
package psdc_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned DerW   = 18;
  localparam int unsigned IntW   = 32;
  localparam int unsigned ProdPW = 33;
  localparam int unsigned ProdIW = 48;
  localparam int unsigned ProdDW = 34;
  localparam int unsigned AccW   = 50;
  localparam int unsigned FracW  = 8;
  localparam int unsigned ShW    = AccW - FracW;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_GAIN_P   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OUT_LOW  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OUT_HIGH = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DEADBAND = 3'd5;

  typedef struct packed {
    logic signed [DataW-1:0] gain_p;
    logic signed [DataW-1:0] gain_i;
    logic signed [DataW-1:0] gain_d;
    logic signed [DataW-1:0] out_low;
    logic signed [DataW-1:0] out_high;
    logic [DataW-1:0]        deadband;
  } psdc_cfg_t;

  localparam psdc_cfg_t CFG_RESET = '{
    gain_p:   16'sd256,
    gain_i:   16'sd0,
    gain_d:   16'sd0,
    out_low:  16'sh8000,
    out_high: 16'sh7fff,
    deadband: 16'd0
  };

  // classified request passed from front to back
  typedef struct packed {
    logic signed [ErrW-1:0] err;
    logic                   in_db;
  } psdc_item_t;

  localparam logic signed [IntW-1:0] INT_MAX = {1'b0, {(IntW-1){1'b1}}};
  localparam logic signed [IntW-1:0] INT_MIN = {1'b1, {(IntW-1){1'b0}}};

endpackage

### rtl/psdc_if.sv
interface psdc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] setpoint;
  logic signed [15:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink (input valid, input setpoint, input measured, output ready);
endinterface

interface psdc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic               clamped;
  logic               in_deadband;

  modport source (output valid, output drive, output clamped, output in_deadband,
                  input ready);
  modport sink (input valid, input drive, input clamped, input in_deadband,
                output ready);
endinterface

### rtl/psdc_front.sv
module psdc_front
  import psdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  psdc_in_if.sink          in_ch,
  input  logic [DataW-1:0] deadband,
  output logic             push_valid,
  output psdc_item_t       push_item,
  input  logic             push_ready
);

  logic                   f_valid_r;
  logic                   f_valid_nxt;
  psdc_item_t             f_item_r;
  psdc_item_t             f_item_nxt;
  logic                   load;
  logic signed [ErrW-1:0] err;
  logic [ErrW-1:0]        mag;

  assign in_ch.ready = !f_valid_r || push_ready;
  assign load        = in_ch.valid && in_ch.ready;

  assign err = ErrW'(in_ch.setpoint) - ErrW'(in_ch.measured);
  assign mag = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);

  always_comb begin
    f_item_nxt       = f_item_r;
    f_item_nxt.err   = err;
    f_item_nxt.in_db = mag <= {1'b0, deadband};
    f_valid_nxt      = f_valid_r;
    if (load) begin
      f_valid_nxt = 1'b1;
    end else if (push_ready) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f_item_r <= f_item_nxt;
    end
  end

  assign push_valid = f_valid_r;
  assign push_item  = f_item_r;

endmodule

### rtl/psdc_queue.sv
module psdc_queue
  import psdc_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  psdc_item_t push_item,
  output logic       push_ready,
  output logic       pop_valid,
  output psdc_item_t pop_item,
  input  logic       pop
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  psdc_item_t      mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count_r != CntW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/psdc_back.sv
module psdc_back
  import psdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  psdc_cfg_t  cfg,
  input  logic       q_valid,
  input  psdc_item_t q_item,
  output logic       q_pop,
  psdc_out_if.source out_ch
);

  logic                     adv;
  logic                     upd;

  // controller state
  logic signed [IntW-1:0]   integ_r;
  logic signed [IntW-1:0]   integ_nxt;
  logic signed [ErrW-1:0]   prev_r;
  logic                     sat_r;
  logic                     sat_nxt;

  // state update stage
  logic                     s1_v_r;
  logic                     s1_db_r;
  logic signed [ErrW-1:0]   s1_err_r;
  logic signed [IntW-1:0]   s1_int_r;
  logic signed [DerW-1:0]   s1_der_r;
  logic signed [IntW:0]     sum;
  logic signed [IntW-1:0]   sum_sat;
  logic                     flip;
  logic signed [DerW-1:0]   der;

  // product stage
  logic                     s2_v_r;
  logic                     s2_db_r;
  logic signed [ProdPW-1:0] pp_r;
  logic signed [ProdIW-1:0] pi_r;
  logic signed [ProdDW-1:0] pd_r;
  logic signed [DataW-1:0]  gp;
  logic signed [DataW-1:0]  gi;
  logic signed [DataW-1:0]  gd;
  logic signed [ProdPW-1:0] pp;
  logic signed [ProdIW-1:0] pi;
  logic signed [ProdDW-1:0] pd;

  // sum stage
  logic                     s3_v_r;
  logic                     s3_db_r;
  logic signed [AccW-1:0]   acc_r;
  logic signed [AccW-1:0]   acc;

  // clamp and output
  logic signed [ShW-1:0]    sh;
  logic signed [ShW-1:0]    lo_ext;
  logic signed [ShW-1:0]    hi_ext;
  logic signed [DataW-1:0]  lo;
  logic signed [DataW-1:0]  hi;
  logic signed [DataW-1:0]  clip;
  logic                     clip_hit;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [DataW-1:0]  out_drive_r;
  logic                     out_clamped_r;
  logic                     out_db_r;

  assign adv   = !out_valid_r || out_ch.ready;
  assign q_pop = adv;
  assign upd   = adv && q_valid && !q_item.in_db;

  assign sum     = (IntW+1)'(integ_r) + (IntW+1)'(q_item.err);
  assign sum_sat = (sum[IntW] != sum[IntW-1]) ? (sum[IntW] ? INT_MIN : INT_MAX)
                                              : sum[IntW-1:0];
  assign flip = (!q_item.err[ErrW-1] && q_item.err != '0 && prev_r[ErrW-1])
             || (q_item.err[ErrW-1] && !prev_r[ErrW-1] && prev_r != '0);
  assign integ_nxt = flip ? '0 : sum_sat;
  assign der       = DerW'(q_item.err) - DerW'(prev_r);

  assign gp = cfg.gain_p;
  assign gi = cfg.gain_i;
  assign gd = cfg.gain_d;
  assign pp = ProdPW'(gp) * ProdPW'(s1_err_r);
  assign pi = ProdIW'(gi) * ProdIW'(s1_int_r);
  assign pd = ProdDW'(gd) * ProdDW'(s1_der_r);

  assign acc = AccW'(pp_r) + AccW'(pi_r) + AccW'(pd_r);

  assign lo     = cfg.out_low;
  assign hi     = cfg.out_high;
  assign sh     = ShW'(acc_r >>> FracW);
  assign lo_ext = ShW'(lo);
  assign hi_ext = ShW'(hi);

  always_comb begin
    clip     = sh[DataW-1:0];
    clip_hit = 1'b0;
    if (sh > hi_ext) begin
      clip     = hi;
      clip_hit = 1'b1;
    end else if (sh < lo_ext) begin
      clip     = lo;
      clip_hit = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = adv ? s3_v_r : out_valid_r;
    sat_nxt       = sat_r;
    if (adv && s3_v_r && !s3_db_r) begin
      sat_nxt = clip_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      prev_r      <= '0;
      sat_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (upd) begin
        integ_r <= integ_nxt;
        prev_r  <= q_item.err;
      end
      if (adv) begin
        s1_v_r <= q_valid;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
      end
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_db_r  <= q_item.in_db;
      s1_err_r <= q_item.err;
      s1_int_r <= integ_nxt;
      s1_der_r <= der;
      s2_db_r  <= s1_db_r;
      pp_r     <= pp;
      pi_r     <= pi;
      pd_r     <= pd;
      s3_db_r  <= s2_db_r;
      acc_r    <= acc;
      if (s3_db_r) begin
        out_drive_r   <= '0;
        out_clamped_r <= sat_r;
        out_db_r      <= 1'b1;
      end else begin
        out_drive_r   <= clip;
        out_clamped_r <= clip_hit;
        out_db_r      <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive       = out_drive_r;
  assign out_ch.clamped     = out_clamped_r;
  assign out_ch.in_deadband = out_db_r;

endmodule

### rtl/pid_step_deadband_clamp.sv
// pid step with deadband and output clamp
// in_ch carries setpoint and measured; a request is taken when valid and ready
// are high at a rising edge of clk. out_ch returns one result per request, in
// order: drive, clamped (saturation flag after the step) and in_deadband.
// cfg_we writes cfg_data into register cfg_index at the clock edge: 0 gain_p,
// 1 gain_i, 2 gain_d, 3 out_low, 4 out_high, 5 deadband; other indexes are
// ignored. write registers only while no request is in flight.
// throughput is one request per cycle while results are taken: a front
// register classifies the error against the deadband, a QUEUE_DEPTH entry
// queue decouples it from the back end, which updates integral and last
// error in its state update stage and then runs products, sum and clamp as
// three pipeline stages.
// a held result with out_ch.ready low stalls the whole back end; the queue
// and front register keep taking requests until full, then in_ch.ready drops.
// rst_n (synchronous, active low) clears integral, last error, saturation
// flag, all valid bits and restores the register defaults.
module pid_step_deadband_clamp
  import psdc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  psdc_in_if.sink            in_ch,
  psdc_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data
);

  psdc_cfg_t  cfg_r;
  psdc_cfg_t  cfg_nxt;
  logic       push_valid;
  psdc_item_t push_item;
  logic       push_ready;
  logic       q_valid;
  psdc_item_t q_item;
  logic       q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:   cfg_nxt.gain_p   = cfg_data;
        REG_GAIN_I:   cfg_nxt.gain_i   = cfg_data;
        REG_GAIN_D:   cfg_nxt.gain_d   = cfg_data;
        REG_OUT_LOW:  cfg_nxt.out_low  = cfg_data;
        REG_OUT_HIGH: cfg_nxt.out_high = cfg_data;
        REG_DEADBAND: cfg_nxt.deadband = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  psdc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .deadband   (cfg_r.deadband),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  psdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  psdc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  a_db_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.in_deadband |-> out_ch.drive == '0)
    else $error("deadband result with nonzero drive");

  a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.in_deadband && (cfg_r.out_low <= cfg_r.out_high)
    |-> (out_ch.drive >= cfg_r.out_low) && (out_ch.drive <= cfg_r.out_high))
    else $error("drive outside clamp bounds");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

### sim/pid_drive_checker.sv
module pid_drive_checker
  import psdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data,
  psdc_in_if                 in_mon,
  psdc_out_if                out_mon,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] drive;
    logic               clamped;
    logic               in_deadband;
  } drive_result_t;

  psdc_cfg_t          regs;
  logic signed [31:0] integral;
  logic signed [16:0] last_err;
  logic               sat_flag;
  drive_result_t      expected_drives[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic drive_result_t next_drive(input logic signed [15:0] sp,
                                               input logic signed [15:0] ms);
    logic signed [16:0] err;
    logic [16:0]        mag;
    logic signed [32:0] sum;
    logic signed [17:0] deriv;
    longint             acc;
    longint             drv;
    drive_result_t      res;
    err = {sp[15], sp} - {ms[15], ms};
    mag = err[16] ? -err : err;
    if (mag <= {1'b0, regs.deadband}) begin
      res.drive = '0;
      res.clamped = sat_flag;
      res.in_deadband = 1'b1;
      return res;
    end
    sum = {integral[31], integral} + {{16{err[16]}}, err};
    if (sum[32] != sum[31]) begin
      integral = sum[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      integral = sum[31:0];
    end
    // integral restarts when the error changes sign
    if ((err > 0 && last_err < 0) || (err < 0 && last_err > 0)) begin
      integral = '0;
    end
    deriv = {err[16], err} - {last_err[16], last_err};
    last_err = err;
    acc = longint'(regs.gain_p) * longint'(err) + longint'(regs.gain_i) * longint'(integral)
        + longint'(regs.gain_d) * longint'(deriv);
    drv = acc >>> 8;
    // ceiling test first: with crossed bounds, values above out_high give out_high, all others out_low
    if (drv > longint'(regs.out_high)) begin
      drv = regs.out_high;
      sat_flag = 1'b1;
    end else if (drv < longint'(regs.out_low)) begin
      drv = regs.out_low;
      sat_flag = 1'b1;
    end else begin
      sat_flag = 1'b0;
    end
    res.drive = 16'(drv);
    res.clamped = sat_flag;
    res.in_deadband = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    drive_result_t want;
    if (!rst_n) begin
      regs = CFG_RESET;
      integral = '0;
      last_err = '0;
      sat_flag = 1'b0;
      expected_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:   regs.gain_p = cfg_data;
          REG_GAIN_I:   regs.gain_i = cfg_data;
          REG_GAIN_D:   regs.gain_d = cfg_data;
          REG_OUT_LOW:  regs.out_low = cfg_data;
          REG_OUT_HIGH: regs.out_high = cfg_data;
          REG_DEADBAND: regs.deadband = cfg_data;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_drives.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: drive %0d clamped %0b in_deadband %0b",
                     out_mon.drive, out_mon.clamped, out_mon.in_deadband);
          end
        end else begin
          want = expected_drives.pop_front();
          if (out_mon.drive !== want.drive || out_mon.clamped !== want.clamped ||
              out_mon.in_deadband !== want.in_deadband) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected drive %0d clamped %0b in_deadband %0b, got drive %0d clamped %0b in_deadband %0b",
                       want.drive, want.clamped, want.in_deadband,
                       out_mon.drive, out_mon.clamped, out_mon.in_deadband);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_drives.push_back(next_drive(in_mon.setpoint, in_mon.measured));
      end
    end
    pending = expected_drives.size();
  end

endmodule

### sim/pid_step_deadband_clamp_tb.sv
module pid_step_deadband_clamp_tb;
  import psdc_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomPerSetting = 238;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DataW-1:0]   cfg_data;
  logic [15:0]        db_now;
  int                 fail_count;
  int                 pending;
  int                 idle_pct;
  int                 stall_pct;
  int                 quiet_cycles = 0;

  psdc_in_if  in_ch ();
  psdc_out_if out_ch ();

  always #5 clk = ~clk;

  pid_step_deadband_clamp dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pid_drive_checker drive_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(input logic signed [15:0] sp, input logic signed [15:0] ms);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.setpoint <= sp;
    in_ch.measured <= ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  // drain outstanding requests, then rewrite every register
  task automatic load_registers(input logic signed [15:0] gp, input logic signed [15:0] gi,
                                input logic signed [15:0] gd, input logic signed [15:0] lo,
                                input logic signed [15:0] hi, input logic [15:0] db);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    write_register(REG_GAIN_P, gp);
    write_register(REG_GAIN_I, gi);
    write_register(REG_GAIN_D, gd);
    write_register(REG_OUT_LOW, lo);
    write_register(REG_OUT_HIGH, hi);
    write_register(REG_DEADBAND, db);
    cfg_we <= 1'b0;
    db_now = db;
  endtask

  function automatic int rand_s16();
    logic signed [15:0] v;
    v = 16'($urandom);
    return v;
  endfunction

  function automatic int pick_edge();
    case ($urandom_range(2))
      0: return -32768;
      1: return 32767;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_gain();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3, 4: return 16'($urandom_range(1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_setting(input int kind);
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic [15:0]        db;
    case (kind)
      0: load_registers(16'sd256, 16'sd0, 16'sd0, 16'sh8000, 16'sh7fff, 16'd0);
      1: load_registers(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'hffff);
      2: load_registers(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'd0);
      default: begin
        a = 16'($urandom);
        b = 16'($urandom);
        case ($urandom_range(3))
          0: db = 16'd0;
          1: db = 16'($urandom_range(64));
          2: db = 16'($urandom_range(2000));
          default: db = 16'($urandom);
        endcase
        // ordered bounds most of the time, crossed now and then
        if ($urandom_range(3) == 0 || a <= b) begin
          load_registers(rand_gain(), rand_gain(), rand_gain(), a, b, db);
        end else begin
          load_registers(rand_gain(), rand_gain(), rand_gain(), b, a, db);
        end
      end
    endcase
  endtask

  task automatic make_sample(output logic signed [15:0] sp, output logic signed [15:0] ms);
    int s;
    int m;
    int e;
    s = rand_s16();
    m = rand_s16();
    case ($urandom_range(9))
      0, 1, 2: ;
      3, 4, 5: begin
        e = int'($urandom_range(1024)) - 512;
        m = s - e;
      end
      6: begin
        // right at the deadband edge
        e = int'(db_now) + int'($urandom_range(1));
        if ($urandom_range(1) == 1) e = -e;
        m = s - e;
      end
      7: begin
        s = pick_edge();
        m = pick_edge();
      end
      default: begin
        s = int'($urandom_range(40)) - 20;
        m = int'($urandom_range(40)) - 20;
      end
    endcase
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    sp = 16'(s);
    ms = 16'(m);
  endtask

  initial begin
    logic signed [15:0] sp;
    logic signed [15:0] ms;
    in_ch.valid = 1'b0;
    in_ch.setpoint = '0;
    in_ch.measured = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GAIN_P;
    cfg_data = '0;
    rst_n = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    db_now = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default registers: drive follows the error
    push_sample(16'sh7fff, 16'sh8000);
    push_sample(16'sh8000, 16'sh7fff);
    push_sample(16'sd0, 16'sd0);
    push_sample(16'sd100, 16'sd0);
    push_sample(16'sd0, 16'sd100);
    push_sample(16'sd1, 16'sd0);
    push_sample(16'sd0, 16'sd1);
    push_sample(16'sh8000, 16'sh8000);
    push_sample(16'sh7fff, 16'sh7fff);

    // narrow window, extreme gains, deadband edge
    load_registers(16'sh8000, 16'sh7fff, 16'sh7fff, -16'sd100, 16'sd100, 16'd50);
    push_sample(16'sd0, 16'sd50);
    push_sample(16'sd0, 16'sd51);
    push_sample(16'sd0, -16'sd51);
    push_sample(-16'sd40, 16'sd10);
    push_sample(16'sh7fff, 16'sh8000);
    push_sample(16'sh8000, 16'sh7fff);
    push_sample(16'sd50, -16'sd1);

    // crossed bounds, then a held flag inside the deadband
    load_registers(16'sd256, 16'sd0, 16'sd0, 16'sd100, -16'sd100, 16'd0);
    push_sample(16'sd0, 16'sd1);
    push_sample(16'sd0, -16'sd1);
    push_sample(16'sd0, 16'sd300);
    push_sample(16'sd0, -16'sd300);
    push_sample(16'sd0, 16'sd0);

    // integral builds up in both directions
    load_registers(16'sh8000, 16'sd1, 16'sd0, 16'sh8000, 16'sh7fff, 16'd0);
    for (int n = 0; n < 16; n++) push_sample(16'sh7fff, 16'sh8000);
    for (int n = 0; n < 16; n++) push_sample(16'sh8000, 16'sh7fff);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      for (int k = 0; k < 2; k++) begin
        load_setting(phase * 2 + k);
        for (int n = 0; n < RandomPerSetting; n++) begin
          make_sample(sp, ms);
          push_sample(sp, ms);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/psdc_pkg.sv
rtl/psdc_if.sv
rtl/psdc_front.sv
rtl/psdc_queue.sv
rtl/psdc_back.sv
rtl/pid_step_deadband_clamp.sv
sim/pid_drive_checker.sv
sim/pid_step_deadband_clamp_tb.sv
